// ----- rtl/ccpsd_pkg.sv -----
// Package for the charge comparison PSD unit: payload structs, register
// indexes, reset values and arithmetic limits. No dependencies.
`default_nettype none
package ccpsd_pkg;

  localparam int DEFAULT_MAX_SAMPLES = 512;
  localparam int ACC_W               = 26;
  localparam int CFG_IDX_W           = 3;
  localparam int DIV_STEPS           = 40;
  localparam int DIV_CNT_W           = 6;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 26'sh1FFFFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 26'sh2000000;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LINEAR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_QUADRATIC = 3'd5;

  typedef struct packed {
    logic        [8:0]  window_start;
    logic        [9:0]  window_end;
    logic        [12:0] bin_width;
    logic signed [31:0] cal_offset;
    logic signed [31:0] cal_linear;
    logic signed [31:0] cal_quadratic;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    window_start:  9'd50,
    window_end:    10'd137,
    bin_width:     13'd1638,
    cal_offset:    32'sd0,
    cal_linear:    32'sd65536,
    cal_quadratic: 32'sd0
  };

  typedef struct packed {
    logic signed [15:0] sample;
    logic        [23:0] total_charge;
    logic               last_sample;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] partial_charge;
    logic        [23:0]      total_charge_out;
    logic signed [15:0]      charge_ratio;
    logic signed [31:0]      energy;
    logic                    zero_total;
  } out_t;

  // One finished waveform handed from the front to the back
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic        [23:0]      total;
  } job_t;

endpackage
`default_nettype wire

// ----- rtl/ccpsd_fifo.sv -----
// Two-entry queue with registered head, used between front and back and
// at the result side. No dependencies.
`default_nettype none
module ccpsd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [1:0]       count;
  logic [WIDTH-1:0] head;
  logic [WIDTH-1:0] tail;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign dout    = head;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
    if (do_pop) begin
      if (count == 2'd2) begin
        head <= tail;
        if (do_push) begin
          tail <= din;
        end
      end else if (do_push) begin
        head <= din;
      end
    end else if (do_push) begin
      if (count == 2'd0) begin
        head <= din;
      end else begin
        tail <= din;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ccpsd_front.sv -----
// Front end: counts samples, sums the windowed ones with saturation and
// hands each finished waveform to the job queue. Uses ccpsd_pkg.
`default_nettype none
module ccpsd_front
  import ccpsd_pkg::*;
#(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic job_push,
  output job_t job,
  input  logic job_full
);

  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (IDX_W > 10) ? IDX_W : 10;

  logic        [IDX_W-1:0] sample_index;
  logic signed [ACC_W-1:0] window_accumulator;

  logic                    accept;
  logic                    in_range;
  logic                    in_window;
  logic        [CMP_W-1:0] idx_c;
  logic        [CMP_W-1:0] start_c;
  logic        [CMP_W-1:0] end_c;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] acc_next;

  assign full   = job_full;
  assign accept = push & ~job_full;

  assign idx_c     = CMP_W'(sample_index);
  assign start_c   = CMP_W'(cfg.window_start);
  assign end_c     = CMP_W'(cfg.window_end);
  assign in_range  = (sample_index < IDX_W'(MAX_SAMPLES));
  assign in_window = in_range && (idx_c >= start_c) && (idx_c < end_c);
  assign sum       = (ACC_W+1)'(window_accumulator) + (ACC_W+1)'(item.sample);

  always_comb begin
    acc_next = window_accumulator;
    if (in_window) begin
      if (sum > (ACC_W+1)'(ACC_MAX)) begin
        acc_next = ACC_MAX;
      end else if (sum < (ACC_W+1)'(ACC_MIN)) begin
        acc_next = ACC_MIN;
      end else begin
        acc_next = sum[ACC_W-1:0];
      end
    end
  end

  assign job_push  = accept & item.last_sample;
  assign job.acc   = acc_next;
  assign job.total = item.total_charge;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index       <= '0;
      window_accumulator <= '0;
    end else if (accept) begin
      if (item.last_sample) begin
        sample_index       <= '0;
        window_accumulator <= '0;
      end else begin
        window_accumulator <= acc_next;
        if (in_range) begin
          sample_index <= sample_index + IDX_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ccpsd_back.sv -----
// Back end: per-waveform sequencer with one shared multiplier and a
// restoring divider; forms partial charge, ratio and energy. Uses ccpsd_pkg.
`default_nettype none
module ccpsd_back
  import ccpsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic job_valid,
  input  job_t job,
  output logic job_pop,
  output logic res_push,
  output out_t res,
  input  logic res_full
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_P, S_MUL_L, S_MUL_A, S_MUL_H, S_MUL_LO, S_SUM, S_DIV, S_OUT
  } state_t;

  state_t                  state;
  logic signed [ACC_W-1:0] acc_q;
  logic        [23:0]      total_q;
  logic signed [57:0]      mul_q;
  logic signed [ACC_W-1:0] partial_q;
  logic signed [41:0]      lin_q;
  logic        [31:0]      al_q;
  logic signed [51:0]      esum_part_q;
  logic signed [31:0]      energy_q;
  logic                    zero_q;
  logic        [23:0]      rem_q;
  logic        [39:0]      dq;
  logic [DIV_CNT_W-1:0]    cnt;

  logic signed [32:0]      mul_a;
  logic signed [24:0]      mul_b;
  logic signed [57:0]      rounded;
  logic signed [ACC_W-1:0] partial_sat;
  logic signed [57:0]      lin_full;
  logic signed [51:0]      lin_ext;
  logic signed [51:0]      hi_ext;
  logic signed [51:0]      off_ext;
  logic signed [51:0]      lo_ext;
  logic signed [51:0]      esum;
  logic signed [31:0]      energy_sat;
  logic        [ACC_W-1:0] pmag;
  logic        [24:0]      trial_in;
  logic        [24:0]      trial_diff;
  logic                    trial_ge;
  logic signed [15:0]      ratio;

  always_comb begin
    mul_a = '0;
    mul_b = $signed({1'b0, total_q});
    case (state)
      S_MUL_P: begin
        mul_a = 33'(acc_q);
        mul_b = $signed({12'b0, cfg.bin_width});
      end
      S_MUL_L:  mul_a = 33'(cfg.cal_linear);
      S_MUL_A:  mul_a = 33'(cfg.cal_quadratic);
      S_MUL_H:  mul_a = 33'($signed(mul_q[57:32]));
      S_MUL_LO: mul_a = $signed({1'b0, al_q});
      default:  mul_a = '0;
    endcase
  end

  assign rounded = (mul_q + 58'sd2048) >>> 12;

  always_comb begin
    if (rounded > 58'(ACC_MAX)) begin
      partial_sat = ACC_MAX;
    end else if (rounded < 58'(ACC_MIN)) begin
      partial_sat = ACC_MIN;
    end else begin
      partial_sat = rounded[ACC_W-1:0];
    end
  end

  assign lin_full = mul_q >>> 16;
  assign lin_ext  = 52'(lin_q);
  assign hi_ext   = 52'($signed(mul_q[50:0]));
  assign off_ext  = 52'(cfg.cal_offset);
  assign lo_ext   = $signed({28'b0, mul_q[55:32]});
  assign esum     = off_ext + esum_part_q + lo_ext;

  always_comb begin
    if (esum > 52'sd2147483647) begin
      energy_sat = 32'sh7FFFFFFF;
    end else if (esum < -52'sd2147483648) begin
      energy_sat = 32'sh80000000;
    end else begin
      energy_sat = esum[31:0];
    end
  end

  assign pmag       = partial_q[ACC_W-1] ? ACC_W'(-partial_q) : ACC_W'(partial_q);
  assign trial_in   = {rem_q, dq[39]};
  assign trial_ge   = (trial_in >= {1'b0, total_q});
  assign trial_diff = trial_in - {1'b0, total_q};

  always_comb begin
    if (zero_q) begin
      ratio = '0;
    end else if (!partial_q[ACC_W-1]) begin
      ratio = (dq > 40'd32767) ? 16'sh7FFF : $signed(dq[15:0]);
    end else begin
      ratio = (dq > 40'd32768) ? 16'sh8000 : $signed(16'd0 - dq[15:0]);
    end
  end

  assign job_pop  = (state == S_IDLE) && job_valid;
  assign res_push = (state == S_OUT) && !res_full;

  assign res.partial_charge   = partial_q;
  assign res.total_charge_out = total_q;
  assign res.charge_ratio     = ratio;
  assign res.energy           = energy_q;
  assign res.zero_total       = zero_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      mul_q <= mul_a * mul_b;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            acc_q   <= job.acc;
            total_q <= job.total;
            state   <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          state <= S_MUL_L;
        end
        S_MUL_L: begin
          partial_q <= partial_sat;
          state     <= S_MUL_A;
        end
        S_MUL_A: begin
          lin_q <= lin_full[41:0];
          state <= S_MUL_H;
        end
        S_MUL_H: begin
          al_q  <= mul_q[31:0];
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          esum_part_q <= lin_ext + hi_ext;
          state       <= S_SUM;
        end
        S_SUM: begin
          energy_q <= energy_sat;
          zero_q   <= (total_q == 24'd0);
          rem_q    <= '0;
          dq       <= {pmag, 14'b0};
          cnt      <= DIV_CNT_W'(DIV_STEPS - 1);
          state    <= (total_q == 24'd0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          rem_q <= trial_ge ? trial_diff[23:0] : trial_in[23:0];
          dq    <= {dq[38:0], trial_ge};
          if (cnt == '0) begin
            state <= S_OUT;
          end else begin
            cnt <= cnt - DIV_CNT_W'(1);
          end
        end
        S_OUT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/charge_comparison_psd_unit.sv -----
// Top level of the charge comparison PSD unit: configuration registers,
// front end, job queue, back end and result queue. Uses all ccpsd files.
`default_nettype none
// Samples enter at one per clock while full is low and are windowed and
// summed as they arrive. The sample marked last closes a waveform and
// places it in a two-entry job queue; full rises only while that queue
// holds two waveforms. The back end runs one waveform at a time through a
// load step, 5 steps of a shared 33x25 multiplier, a sum step, 40 steps of
// a radix-2 divider (skipped when the total is zero) and an output step,
// so waveforms with at least as many samples as those steps stream without
// stall while results are popped; shorter ones are held off by full. The
// output step lasts until the result queue has room. Results wait in a
// two-entry result queue. Configuration is taken at once (cfg_ready is
// always high) and should change only while no waveform is in flight.
module charge_comparison_psd_unit
  import ccpsd_pkg::*;
#(
  parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_t                  sample_item,
  output logic                 empty,
  input  logic                 pop,
  output out_t                 result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t cfg;
  logic job_push;
  job_t job_in;
  logic job_full;
  logic job_empty;
  logic job_pop;
  job_t job_out;
  logic res_push;
  out_t res_in;
  logic res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_START:  cfg.window_start  <= cfg_data[8:0];
        REG_WINDOW_END:    cfg.window_end    <= cfg_data[9:0];
        REG_BIN_WIDTH:     cfg.bin_width     <= cfg_data[12:0];
        REG_CAL_OFFSET:    cfg.cal_offset    <= $signed(cfg_data);
        REG_CAL_LINEAR:    cfg.cal_linear    <= $signed(cfg_data);
        REG_CAL_QUADRATIC: cfg.cal_quadratic <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  ccpsd_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .item     (sample_item),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full)
  );

  ccpsd_fifo #(
    .WIDTH($bits(job_t))
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  ccpsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  ccpsd_fifo #(
    .WIDTH($bits(out_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.zero_total == (result.total_charge_out == 24'd0)))
    else $error("zero_total does not match total charge");

  a_zero_ratio: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.zero_total) |-> (result.charge_ratio == 16'sd0))
    else $error("ratio not cleared for zero total");

  a_ratio_sign: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.charge_ratio[15]) |-> result.partial_charge[ACC_W-1])
    else $error("negative ratio from non-negative partial charge");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking bench for charge_comparison_psd_unit: windowed charge sums,
// charge ratio and calibrated energy checked beat by beat against an
// in-bench prediction. Depends on rtl/ccpsd_pkg.sv and the unit's RTL.
`default_nettype none
module tb_top
  import ccpsd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WAVE_CAP      = DEFAULT_MAX_SAMPLES;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 500;

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 push        = 1'b0;
  logic                 full;
  in_t                  sample_item = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  out_t                 result;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [31:0]          cfg_data    = '0;

  // prediction state
  cfg_t   live_cfg   = CFG_RESET;
  int     wave_pos   = 0;
  longint window_sum = 0;
  out_t   psd_due[$];

  int errors      = 0;
  int rx_hold_req = 0;
  int rx_wait     = 0;
  int rx_run      = 0;

  charge_comparison_psd_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample_item(sample_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($signed($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_total();
    case ($urandom_range(0, 9))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      2, 3, 4: return 24'($urandom_range(1, 2000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(logic [31:0] typical, int spread);
    case ($urandom_range(0, 9))
      0:          return 32'h7FFFFFFF;
      1:          return 32'h80000000;
      2, 3, 4, 5: return typical + 32'($signed($urandom_range(0, 2 * spread)) - spread);
      default:    return $urandom;
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int r;
    r = $urandom_range(0, 19);
    c.window_start = (r < 2) ? 9'd0 : (r == 2) ? 9'd511 : 9'($urandom_range(0, 60));
    r = $urandom_range(0, 19);
    c.window_end = (r < 2) ? 10'd512 : (r == 2) ? 10'd1023 : (r == 3) ? 10'd0 :
                   10'($urandom_range(0, 120));
    r = $urandom_range(0, 9);
    c.bin_width     = (r == 0) ? 13'd0 : (r == 1) ? 13'd8191 : 13'($urandom);
    c.cal_offset    = rand_coef(32'd0, 5000);
    c.cal_linear    = rand_coef(32'd65536, 40000);
    c.cal_quadratic = rand_coef(32'd0, 100000);
    return c;
  endfunction

  // Window one sample; on the last one, form the expected result beat.
  task automatic score_sample(in_t it);
    longint s, p, r, tot, bw;
    logic signed [95:0] t96, off_c, lin_c, quad_c, e96;
    out_t o;
    s   = it.sample;
    tot = it.total_charge;
    bw  = live_cfg.bin_width;
    if (wave_pos < WAVE_CAP && wave_pos >= int'(live_cfg.window_start) &&
        wave_pos < int'(live_cfg.window_end))
      window_sum = clamp(window_sum + s, longint'(ACC_MIN), longint'(ACC_MAX));
    if (wave_pos < WAVE_CAP) wave_pos++;
    if (!it.last_sample) return;

    p = clamp((window_sum * bw + 2048) >>> 12, longint'(ACC_MIN), longint'(ACC_MAX));
    r = (tot == 0) ? 0 : clamp((p * 16384) / tot, -32768, 32767);

    t96    = tot;
    off_c  = $signed(live_cfg.cal_offset);
    lin_c  = $signed(live_cfg.cal_linear);
    quad_c = $signed(live_cfg.cal_quadratic);
    e96 = off_c + ((lin_c * t96) >>> 16) + ((quad_c * t96 * t96) >>> 32);
    if (e96 > 96'sd2147483647) e96 = 96'sd2147483647;
    else if (e96 < -96'sd2147483648) e96 = -96'sd2147483648;

    o.partial_charge   = p[ACC_W-1:0];
    o.total_charge_out = it.total_charge;
    o.charge_ratio     = r[15:0];
    o.energy           = e96[31:0];
    o.zero_total       = (tot == 0);
    psd_due.push_back(o);
    wave_pos   = 0;
    window_sum = 0;
  endtask

  // Result side: check each popped beat, then pick the next pop pattern.
  always @(posedge clk) begin
    out_t want;
    if (!rst && pop && !empty) begin
      if (psd_due.size() == 0) begin
        $error("unexpected result beat: partial_charge %0d", result.partial_charge);
        errors++;
      end else begin
        want = psd_due.pop_front();
        if (result.partial_charge !== want.partial_charge) begin
          $error("partial_charge: expected %0d, got %0d",
                 want.partial_charge, result.partial_charge);
          errors++;
        end
        if (result.total_charge_out !== want.total_charge_out) begin
          $error("total_charge_out: expected %0d, got %0d",
                 want.total_charge_out, result.total_charge_out);
          errors++;
        end
        if (result.charge_ratio !== want.charge_ratio) begin
          $error("charge_ratio: expected %0d, got %0d",
                 want.charge_ratio, result.charge_ratio);
          errors++;
        end
        if (result.energy !== want.energy) begin
          $error("energy: expected %0d, got %0d", want.energy, result.energy);
          errors++;
        end
        if (result.zero_total !== want.zero_total) begin
          $error("zero_total: expected %0d, got %0d", want.zero_total, result.zero_total);
          errors++;
        end
      end
    end
    if (rx_hold_req != 0) begin
      rx_wait     = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_wait > 0) begin
      pop <= 1'b0;
      rx_wait--;
    end else begin
      pop <= 1'b1;
      if (rx_run > 0) rx_run--;
      else if ($urandom_range(0, 19) == 0) rx_run = $urandom_range(50, 200);
      else rx_wait = pick_gap();
    end
  end

  // One input beat; leaves push high so a following beat can go back to back.
  task automatic offer_sample(in_t it, bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    sample_item <= it;
    do @(posedge clk); while (full);
    score_sample(it);
  endtask

  task automatic send_random_wave(int len, bit steady);
    in_t it;
    for (int i = 0; i < len; i++) begin
      it.sample       = rand_sample();
      it.total_charge = rand_total();
      it.last_sample  = (i == len - 1);
      offer_sample(it, steady);
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (psd_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WINDOW_START:  live_cfg.window_start  = data[8:0];
      REG_WINDOW_END:    live_cfg.window_end    = data[9:0];
      REG_BIN_WIDTH:     live_cfg.bin_width     = data[12:0];
      REG_CAL_OFFSET:    live_cfg.cal_offset    = data;
      REG_CAL_LINEAR:    live_cfg.cal_linear    = data;
      REG_CAL_QUADRATIC: live_cfg.cal_quadratic = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(cfg_t c);
    write_reg(REG_WINDOW_START, 32'(c.window_start));
    write_reg(REG_WINDOW_END, 32'(c.window_end));
    write_reg(REG_BIN_WIDTH, 32'(c.bin_width));
    write_reg(REG_CAL_OFFSET, c.cal_offset);
    write_reg(REG_CAL_LINEAR, c.cal_linear);
    write_reg(REG_CAL_QUADRATIC, c.cal_quadratic);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_settings();
    send_random_wave(140, 1'b0);
  endtask

  task automatic test_directed();
    drain_results();
    apply_settings('{9'd0, 10'd4, 13'd4096, 32'd0, 32'd65536, 32'd0});
    // ratio saturates high, then low
    repeat (3) offer_sample('{16'sh7FFF, 24'd0, 1'b0}, 1'b0);
    offer_sample('{16'sh7FFF, 24'd1, 1'b1}, 1'b0);
    repeat (3) offer_sample('{16'sh8000, 24'd5, 1'b0}, 1'b0);
    offer_sample('{16'sh8000, 24'd1, 1'b1}, 1'b0);
    // zero total on a one-sample waveform
    offer_sample('{16'sh1234, 24'd0, 1'b1}, 1'b0);
    offer_sample('{16'sd100, 24'hFFFFFF, 1'b0}, 1'b0);
    offer_sample('{-16'sd50, 24'hFFFFFF, 1'b0}, 1'b0);
    offer_sample('{16'sd7, 24'hFFFFFF, 1'b1}, 1'b0);
    // samples past the window end
    repeat (5) offer_sample('{16'sd1, 24'd0, 1'b0}, 1'b1);
    offer_sample('{16'sd1, 24'd3, 1'b1}, 1'b1);

    // empty window, energy saturates high
    drain_results();
    apply_settings('{9'd5, 10'd5, 13'd8191, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
    repeat (2) offer_sample('{16'sh7FFF, 24'd0, 1'b0}, 1'b0);
    offer_sample('{16'sh7FFF, 24'hFFFFFF, 1'b1}, 1'b0);

    // start above end, energy saturates low
    drain_results();
    apply_settings('{9'd9, 10'd2, 13'd0, 32'h80000000, 32'h80000000, 32'h80000000});
    offer_sample('{16'sh8000, 24'd0, 1'b0}, 1'b0);
    offer_sample('{16'sh8000, 24'hFFFFFF, 1'b1}, 1'b0);

    // negative quadratic term on a large total
    drain_results();
    apply_settings('{9'd0, 10'd1023, 13'd1, 32'd0, 32'd0, 32'hFFFFFFFF});
    offer_sample('{16'sh7FFF, 24'd0, 1'b0}, 1'b0);
    offer_sample('{-16'sd3, 24'h800000, 1'b1}, 1'b0);
  endtask

  task automatic test_long_waveform();
    drain_results();
    apply_settings('{9'd500, 10'd1023, 13'd8191, 32'd17, 32'd70000, 32'd3000});
    send_random_wave(530, 1'b0);
  endtask

  task automatic test_backpressure();
    in_t it;
    drain_results();
    apply_settings('{9'd0, 10'd1, 13'd2048, 32'd0, 32'd65536, 32'd0});
    rx_hold_req = 400;
    for (int i = 0; i < 40; i++) begin
      it.sample       = rand_sample();
      it.total_charge = rand_total();
      it.last_sample  = 1'b1;
      offer_sample(it, 1'b1);
    end
    drain_results();
  endtask

  task automatic test_random();
    int sent, phase_items, len, r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      apply_settings(rand_cfg());
      phase_items = 0;
      while (phase_items < 130) begin
        r = $urandom_range(0, 99);
        if (r < 20) len = $urandom_range(1, 3);
        else if (r < 75) len = $urandom_range(4, 50);
        else len = $urandom_range(51, 160);
        send_random_wave(len, $urandom_range(0, 3) == 0);
        phase_items += len;
      end
      sent += phase_items;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_settings();
    test_directed();
    test_long_waveform();
    test_backpressure();
    test_random();
    drain_results();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
